@@ hdl/ptw_pkg.sv @@
// Shared types, codes and helpers for the four-level page table walker.
`timescale 1ns / 1ps

package ptw_pkg;

    // Field widths.
    localparam int VA_W       = 48;
    localparam int PA_W       = 52;
    localparam int ENTRY_W    = 64;
    localparam int IDX_W      = 9;
    localparam int PAGE_OFS_W = 12;

    // Default physical address width.
    localparam int PHYS_BITS_DEF = 52;

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_DATA_W = 168;
    localparam int M_DATA_W = 112;

    // Table entry bit positions.
    localparam int ENTRY_PRESENT_BIT = 0;
    localparam int ENTRY_PS_BIT      = 7;

    // Request selector on the input side.
    typedef enum logic {
        FUNC_START    = 1'b0,
        FUNC_RESPONSE = 1'b1
    } func_t;

    // Kind of result on the output side.
    typedef enum logic {
        KIND_READ   = 1'b0,
        KIND_FINISH = 1'b1
    } kind_t;

    // Translation status codes.
    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_NOT_PRESENT = 2'd1,
        STATUS_FAULT       = 2'd2,
        STATUS_RSVD        = 2'd3
    } status_t;

    // Page size codes.
    typedef enum logic [1:0] {
        SIZE_4K   = 2'd0,
        SIZE_2M   = 2'd1,
        SIZE_1G   = 2'd2,
        SIZE_RSVD = 2'd3
    } size_t;

    // Table levels of the walk.
    typedef enum logic [1:0] {
        LVL_PML4 = 2'd0,
        LVL_PDP  = 2'd1,
        LVL_PD   = 2'd2,
        LVL_PT   = 2'd3
    } level_t;

    // One result item.
    typedef struct packed {
        kind_t             kind;
        logic [PA_W-1:0]   read_address;
        status_t           status;
        logic [PA_W-1:0]   phys_base;
        size_t             page_size_code;
    } result_t;

    // Nine-bit table index of a virtual address for one level.
    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                     input level_t lvl);
        logic [IDX_W-1:0] idx;
        unique case (lvl)
            LVL_PML4: idx = va[47:39];
            LVL_PDP:  idx = va[38:30];
            LVL_PD:   idx = va[29:21];
            LVL_PT:   idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

@@ hdl/four_level_page_table_walker_top.sv @@
// Top level of the four-level page table walker: walk control and result buffer.
`timescale 1ns / 1ps

// The walker takes one request per cycle while s_axis_tready is high and answers
// each with at most one result, registered when the request is accepted. A start
// request (tuser 0) resets the walk and yields the read request for the PML4 entry;
// each response (tuser 1) yields either the read request for the next level or
// the finished translation. A response that arrives while no walk is active is
// dropped without a result, and a start during a walk abandons that walk. The
// result side has a two-entry buffer, so s_axis_tready stays high unless two
// results are waiting; with m_axis_tready high the block sustains one request
// per cycle. Table entries are read by the user: the block only issues the
// address and consumes the returned entry.
module four_level_page_table_walker_top #(
    parameter int PHYS_BITS = ptw_pkg::PHYS_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [47:0] virt_addr, [99:48] root_table, [163:100] entry_data,
    // [164] read_error, [167:165] zero
    input  logic [ptw_pkg::S_DATA_W-1:0] s_axis_tdata,
    // [0] func
    input  logic                         s_axis_tuser,

    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [51:0] read_address, [53:52] status, [105:54] phys_base,
    // [107:106] page_size_code, [111:108] zero
    output logic [ptw_pkg::M_DATA_W-1:0] m_axis_tdata,
    // [0] kind
    output logic                         m_axis_tuser
);

    localparam int PA_W    = ptw_pkg::PA_W;
    localparam int VA_W    = ptw_pkg::VA_W;
    localparam int ENTRY_W = ptw_pkg::ENTRY_W;
    localparam int OFS_W   = ptw_pkg::PAGE_OFS_W;
    localparam int IDX_W   = ptw_pkg::IDX_W;

    // Keeps the implemented physical address bits above the page offset.
    localparam logic [PA_W-1:0] PA_MASK =
        ((PA_W'(1) << PHYS_BITS) - PA_W'(1)) & ~((PA_W'(1) << OFS_W) - PA_W'(1));

    // Unpacked request fields.
    ptw_pkg::func_t      in_func;
    logic [VA_W-1:0]     in_virt_addr;
    logic [PA_W-1:0]     in_root_table;
    logic [ENTRY_W-1:0]  in_entry_data;
    logic                in_read_error;

    assign in_func       = ptw_pkg::func_t'(s_axis_tuser);
    assign in_virt_addr  = s_axis_tdata[47:0];
    assign in_root_table = s_axis_tdata[99:48];
    assign in_entry_data = s_axis_tdata[163:100];
    assign in_read_error = s_axis_tdata[164];

    // Walk state.
    logic                walk_busy_reg,   walk_busy_next;
    ptw_pkg::level_t     walk_level_reg,  walk_level_next;
    logic [VA_W-1:0]     saved_vaddr_reg, saved_vaddr_next;

    // Result buffer: head entry drives the port, skid entry catches overflow.
    logic                out_valid_reg;
    ptw_pkg::result_t    out_data_reg;
    logic                skid_valid_reg;
    ptw_pkg::result_t    skid_data_reg;

    logic                accept;
    logic                pop;
    logic                push;
    logic                has_result;
    ptw_pkg::result_t    result;

    logic [PA_W-1:0]     entry_base;
    logic [PA_W-1:0]     root_base;
    logic [IDX_W-1:0]    start_idx;
    logic [IDX_W-1:0]    next_idx;
    ptw_pkg::level_t     next_level;
    logic                go_down;

    assign s_axis_tready = ~skid_valid_reg;
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign pop           = out_valid_reg & m_axis_tready;
    assign push          = accept & has_result;

    // Table bases and indexes for the next read.
    assign root_base  = in_root_table & PA_MASK;
    assign entry_base = in_entry_data[PA_W-1:0] & PA_MASK;
    assign next_level = ptw_pkg::level_t'(walk_level_reg + 2'd1);
    assign start_idx  = ptw_pkg::level_index(in_virt_addr, ptw_pkg::LVL_PML4);
    assign next_idx   = ptw_pkg::level_index(saved_vaddr_reg, next_level);

    // One step of the walk for the current request.
    always_comb begin
        walk_busy_next   = walk_busy_reg;
        walk_level_next  = walk_level_reg;
        saved_vaddr_next = saved_vaddr_reg;
        has_result       = 1'b0;
        go_down          = 1'b0;
        result           = '0;

        if (in_func == ptw_pkg::FUNC_START) begin
            // New walk: read the PML4 entry.
            saved_vaddr_next    = in_virt_addr;
            walk_busy_next      = 1'b1;
            walk_level_next     = ptw_pkg::LVL_PML4;
            has_result          = 1'b1;
            result.kind         = ptw_pkg::KIND_READ;
            result.read_address = {root_base[PA_W-1:OFS_W], start_idx, 3'b000};
        end else if (walk_busy_reg) begin
            has_result = 1'b1;
            priority if (in_read_error) begin
                result.kind   = ptw_pkg::KIND_FINISH;
                result.status = ptw_pkg::STATUS_FAULT;
            end else if (!in_entry_data[ptw_pkg::ENTRY_PRESENT_BIT]) begin
                result.kind   = ptw_pkg::KIND_FINISH;
                result.status = ptw_pkg::STATUS_NOT_PRESENT;
            end else begin
                // Leaf or next table, by level and page size bit.
                unique case (walk_level_reg)
                    ptw_pkg::LVL_PML4: begin
                        go_down = 1'b1;
                    end
                    ptw_pkg::LVL_PDP: begin
                        if (in_entry_data[ptw_pkg::ENTRY_PS_BIT]) begin
                            result.kind           = ptw_pkg::KIND_FINISH;
                            result.phys_base      = entry_base;
                            result.page_size_code = ptw_pkg::SIZE_1G;
                        end else begin
                            go_down = 1'b1;
                        end
                    end
                    ptw_pkg::LVL_PD: begin
                        if (in_entry_data[ptw_pkg::ENTRY_PS_BIT]) begin
                            result.kind           = ptw_pkg::KIND_FINISH;
                            result.phys_base      = entry_base;
                            result.page_size_code = ptw_pkg::SIZE_2M;
                        end else begin
                            go_down = 1'b1;
                        end
                    end
                    ptw_pkg::LVL_PT: begin
                        result.kind           = ptw_pkg::KIND_FINISH;
                        result.phys_base      = entry_base;
                        result.page_size_code = ptw_pkg::SIZE_4K;
                    end
                endcase
            end

            if (go_down) begin
                walk_level_next     = next_level;
                result.kind         = ptw_pkg::KIND_READ;
                result.read_address = {entry_base[PA_W-1:OFS_W], next_idx, 3'b000};
            end else begin
                walk_busy_next  = 1'b0;
                walk_level_next = ptw_pkg::LVL_PML4;
            end
        end
    end

    // Walk state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_busy_reg   <= 1'b0;
            walk_level_reg  <= ptw_pkg::LVL_PML4;
            saved_vaddr_reg <= '0;
        end else if (accept) begin
            walk_busy_reg   <= walk_busy_next;
            walk_level_reg  <= walk_level_next;
            saved_vaddr_reg <= saved_vaddr_next;
        end
    end

    // Result buffer control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result buffer payload.
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_data_reg <= result;
            end else begin
                skid_data_reg <= result;
            end
        end
    end

    // Output packing.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_data_reg.kind;
    assign m_axis_tdata  = {4'b0000,
                            out_data_reg.page_size_code,
                            out_data_reg.phys_base,
                            out_data_reg.status,
                            out_data_reg.read_address};

endmodule

@@ tb/tb_four_level_page_table_walker_top.sv @@
// Self-checking testbench for the four-level page table walker top level.
`timescale 1ns / 1ps

module tb_four_level_page_table_walker_top;

    localparam int VA_W              = ptw_pkg::VA_W;
    localparam int PA_W              = ptw_pkg::PA_W;
    localparam int ENTRY_W           = ptw_pkg::ENTRY_W;
    localparam int IDX_W             = ptw_pkg::IDX_W;
    localparam int PAGE_OFS_W        = ptw_pkg::PAGE_OFS_W;
    localparam int S_DATA_W          = ptw_pkg::S_DATA_W;
    localparam int M_DATA_W          = ptw_pkg::M_DATA_W;
    localparam int ENTRY_PRESENT_BIT = ptw_pkg::ENTRY_PRESENT_BIT;
    localparam int ENTRY_PS_BIT      = ptw_pkg::ENTRY_PS_BIT;

    localparam int WALK_ITEMS     = 1150;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_AT    = 400;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int DRAIN_CYCLES   = 16;

    localparam logic [PA_W-1:0] PAGE_MASK = {{(PA_W - PAGE_OFS_W){1'b1}}, {PAGE_OFS_W{1'b0}}};

    // One request on the input side, before packing.
    typedef struct packed {
        ptw_pkg::func_t      func;
        logic [VA_W-1:0]     va;
        logic [PA_W-1:0]     root;
        logic [ENTRY_W-1:0]  entry;
        logic                err;
    } walk_req_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                s_axis_tuser  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                m_axis_tuser;

    // Requests waiting to be driven and results the walker still owes.
    walk_req_t          walk_reqs[$];
    ptw_pkg::result_t   outputs_due[$];

    // Shadow copy of the walker state.
    logic            shadow_busy  = 1'b0;
    ptw_pkg::level_t shadow_level = ptw_pkg::LVL_PML4;
    logic [VA_W-1:0] shadow_vaddr = '0;

    int mismatches     = 0;
    int total_items    = 0;
    int accepted_items = 0;
    int walk_count     = 0;
    int results_seen   = 0;
    int n_4k = 0, n_2m = 0, n_1g = 0, n_absent = 0, n_fault = 0;
    int n_abandoned = 0, n_dropped = 0;

    logic rx_holding  = 1'b0;
    int   idle_cycles = 0;

    four_level_page_table_walker_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Byte address of the entry for one level: table base plus nine-bit index times eight.
    function automatic logic [PA_W-1:0] entry_addr(input logic [PA_W-1:0] tbl,
                                                   input ptw_pkg::level_t lvl,
                                                   input logic [VA_W-1:0] va);
        logic [IDX_W-1:0] idx;
        idx = IDX_W'(va >> (39 - 9 * int'(lvl)));
        return (tbl & PAGE_MASK) + {idx, 3'b000};
    endfunction

    // Advance the shadow walker by one accepted request and queue the result it owes.
    function automatic void walk_predict(input walk_req_t rq);
        ptw_pkg::result_t r;
        r = '0;
        if (rq.func == ptw_pkg::FUNC_START) begin
            if (shadow_busy)
                n_abandoned++;
            shadow_vaddr   = rq.va;
            shadow_busy    = 1'b1;
            shadow_level   = ptw_pkg::LVL_PML4;
            r.kind         = ptw_pkg::KIND_READ;
            r.read_address = entry_addr(rq.root, ptw_pkg::LVL_PML4, rq.va);
            outputs_due.push_back(r);
        end else if (!shadow_busy) begin
            n_dropped++;
        end else begin
            r.kind = ptw_pkg::KIND_FINISH;
            if (rq.err) begin
                r.status = ptw_pkg::STATUS_FAULT;
                n_fault++;
            end else if (!rq.entry[ENTRY_PRESENT_BIT]) begin
                r.status = ptw_pkg::STATUS_NOT_PRESENT;
                n_absent++;
            end else if (shadow_level == ptw_pkg::LVL_PDP && rq.entry[ENTRY_PS_BIT]) begin
                r.phys_base      = rq.entry[PA_W-1:0] & PAGE_MASK;
                r.page_size_code = ptw_pkg::SIZE_1G;
                n_1g++;
            end else if (shadow_level == ptw_pkg::LVL_PD && rq.entry[ENTRY_PS_BIT]) begin
                r.phys_base      = rq.entry[PA_W-1:0] & PAGE_MASK;
                r.page_size_code = ptw_pkg::SIZE_2M;
                n_2m++;
            end else if (shadow_level == ptw_pkg::LVL_PT) begin
                r.phys_base      = rq.entry[PA_W-1:0] & PAGE_MASK;
                r.page_size_code = ptw_pkg::SIZE_4K;
                n_4k++;
            end else begin
                // Non-leaf entry: descend one level and read the next table.
                r.kind         = ptw_pkg::KIND_READ;
                shadow_level   = ptw_pkg::level_t'(shadow_level + 2'd1);
                r.read_address = entry_addr(rq.entry[PA_W-1:0], shadow_level, shadow_vaddr);
            end
            if (r.kind == ptw_pkg::KIND_FINISH) begin
                shadow_busy  = 1'b0;
                shadow_level = ptw_pkg::LVL_PML4;
            end
            outputs_due.push_back(r);
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic logic [ENTRY_W-1:0] make_entry(input logic present, input logic ps);
        logic [ENTRY_W-1:0] e;
        e                    = {$urandom, $urandom};
        e[ENTRY_PRESENT_BIT] = present;
        e[ENTRY_PS_BIT]      = ps;
        return e;
    endfunction

    function automatic void push_start(input logic [VA_W-1:0] va, input logic [PA_W-1:0] root);
        walk_req_t rq;
        rq.func  = ptw_pkg::FUNC_START;
        rq.va    = va;
        rq.root  = root;
        rq.entry = {$urandom, $urandom};
        rq.err   = 1'($urandom);
        walk_reqs.push_back(rq);
        walk_count++;
        total_items++;
    endfunction

    function automatic void push_resp(input logic [ENTRY_W-1:0] entry, input logic err);
        walk_req_t rq;
        rq.func  = ptw_pkg::FUNC_RESPONSE;
        rq.va    = VA_W'({$urandom, $urandom});
        rq.root  = PA_W'({$urandom, $urandom});
        rq.entry = entry;
        rq.err   = err;
        walk_reqs.push_back(rq);
        total_items++;
    endfunction

    function automatic void push_random_start();
        push_start(VA_W'({$urandom, $urandom}), PA_W'({$urandom, $urandom}));
    endfunction

    // One walk with random content; some end early, some are cut short by a new start.
    function automatic void add_random_walk();
        int   lvl;
        int   roll;
        logic done;
        push_random_start();
        lvl  = 0;
        done = 1'b0;
        while (!done) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                push_resp({$urandom, $urandom}, 1'b1);
                done = 1'b1;
            end else if (roll < 9) begin
                push_resp(make_entry(1'b0, 1'($urandom)), 1'b0);
                done = 1'b1;
            end else if (roll < 12) begin
                push_random_start();
                lvl = 0;
            end else if ((lvl == 1 || lvl == 2) && roll < 40) begin
                push_resp(make_entry(1'b1, 1'b1), 1'b0);
                done = 1'b1;
            end else if (lvl == 3) begin
                push_resp(make_entry(1'b1, 1'($urandom)), 1'b0);
                done = 1'b1;
            end else begin
                // PS is ignored at the top level, so it may take either value there.
                push_resp(make_entry(1'b1, (lvl == 0) ? 1'($urandom) : 1'b0), 1'b0);
                lvl++;
            end
        end
    endfunction

    // Gap length for one side: mode 0 never idles, mode 1 idles briefly, mode 2 mixes in long gaps.
    function automatic int pick_gap(input int mode);
        int roll;
        roll = $urandom_range(0, 99);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return (roll < 70) ? 0 : $urandom_range(1, 3);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 4);
        if (roll < 97)
            return $urandom_range(5, 12);
        return $urandom_range(20, 60);
    endfunction

    // Stimulus, reset and end of run.
    initial begin
        // Directed walks: idle response, a full walk with all-ones fields, every leaf size,
        // faults with and without a present entry, a missing PT entry and an abandoned walk.
        push_resp(make_entry(1'b1, 1'b0), 1'b0);
        push_start({VA_W{1'b1}}, {PA_W{1'b1}});
        push_resp(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_resp(64'hFFFF_FFFF_FFFF_FF7F, 1'b0);
        push_resp(64'hFFFF_FFFF_FFFF_FF7F, 1'b0);
        push_resp(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_start('0, '0);
        push_resp(64'h0000_0000_0000_0001, 1'b1);
        push_start(48'h8000_0000_0000, 52'h0_0000_0000_1000);
        push_resp('0, 1'b0);
        push_random_start();
        push_resp(make_entry(1'b1, 1'b0), 1'b0);
        push_resp(64'hFFF0_0000_0000_0081, 1'b0);
        push_random_start();
        push_resp(make_entry(1'b1, 1'b1), 1'b0);
        push_resp(make_entry(1'b1, 1'b0), 1'b0);
        push_resp(make_entry(1'b1, 1'b1), 1'b0);
        push_random_start();
        push_resp(make_entry(1'b1, 1'b0), 1'b0);
        push_resp(make_entry(1'b1, 1'b0), 1'b0);
        push_resp(make_entry(1'b1, 1'b0), 1'b0);
        push_resp(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
        push_random_start();
        push_resp(make_entry(1'b1, 1'b0), 1'b0);
        push_random_start();
        push_resp(make_entry(1'b1, 1'b0), 1'b0);
        push_resp('0, 1'b1);
        push_resp(make_entry(1'b1, 1'b1), 1'b0);

        // Random walks, with the odd stray response while the walker is idle.
        while (total_items < WALK_ITEMS) begin
            add_random_walk();
            if ($urandom_range(0, 99) < 8)
                push_resp({$urandom, $urandom}, 1'($urandom));
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_items < total_items)
            @(posedge aclk);
        while (outputs_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (outputs_due.size() != 0) begin
            $error("%0d expected results never arrived", outputs_due.size());
            mismatches++;
        end
        $display("Ran %0d requests in %0d walks, checked %0d results: %0d 4K, %0d 2M, %0d 1G,",
                 accepted_items, walk_count, results_seen, n_4k, n_2m, n_1g);
        $display("%0d not present, %0d faults, %0d walks abandoned, %0d idle responses dropped.",
                 n_absent, n_fault, n_abandoned, n_dropped);
        if (mismatches == 0) begin
            $display("tb_four_level_page_table_walker_top passed");
        end else begin
            $display("tb_four_level_page_table_walker_top failed");
        end
        $finish;
    end

    // Request driver: holds a request until accepted, then waits out a random gap.
    int        tx_gap   = 0;
    int        tx_mode  = 0;
    int        tx_cycle = 0;
    walk_req_t tx_req;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            tx_cycle++;
            if (tx_cycle % 128 == 0)
                tx_mode = $urandom_range(0, 2);
            if (s_axis_tvalid && !s_axis_tready) begin
                // Stalled: keep the request on the bus.
            end else if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (walk_reqs.size() != 0) begin
                tx_req        = walk_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= tx_req.func;
                s_axis_tdata  <= {3'b000, tx_req.err, tx_req.entry, tx_req.root, tx_req.va};
                tx_gap        = rx_holding ? 0 : pick_gap(tx_mode);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result ready: random stalls plus one long hold-off that backs up the walker.
    int rx_stall  = 0;
    int rx_mode   = 0;
    int rx_cycle  = 0;
    int rx_taken  = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle % 128 == 64)
                rx_mode = $urandom_range(0, 2);
            if (m_axis_tvalid && m_axis_tready)
                rx_taken++;
            if (!hold_done && rx_taken >= HOLD_OFF_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
                rx_holding    <= 1'b1;
            end else begin
                rx_holding <= 1'b0;
                if (rx_stall > 0) begin
                    rx_stall--;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                    rx_stall      = pick_gap(rx_mode);
                end
            end
        end
    end

    // Monitor: check each accepted result, then predict from each accepted request.
    always @(posedge aclk) begin : monitor
        ptw_pkg::result_t want;
        walk_req_t        seen;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (outputs_due.size() == 0) begin
                    $error("result with no expectation waiting: kind %0d data %h",
                           m_axis_tuser, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = outputs_due.pop_front();
                    check_field("kind", 64'(want.kind), 64'(m_axis_tuser));
                    check_field("read_address", 64'(want.read_address), 64'(m_axis_tdata[51:0]));
                    check_field("status", 64'(want.status), 64'(m_axis_tdata[53:52]));
                    check_field("phys_base", 64'(want.phys_base), 64'(m_axis_tdata[105:54]));
                    check_field("page_size_code", 64'(want.page_size_code),
                                64'(m_axis_tdata[107:106]));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                seen.func  = ptw_pkg::func_t'(s_axis_tuser);
                seen.va    = s_axis_tdata[47:0];
                seen.root  = s_axis_tdata[99:48];
                seen.entry = s_axis_tdata[163:100];
                seen.err   = s_axis_tdata[164];
                walk_predict(seen);
                accepted_items++;
            end
        end
    end

    // Watchdog: ends the run when neither side has moved a request or result for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_four_level_page_table_walker_top failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
